>>> src/kls_pkg.sv
// shared constants, types and helpers for the keyed lowest-free-slot allocator
package kls_pkg;

  localparam int NUM_SLOTS  = 32;
  localparam int KEY_BITS   = 64;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int KEY_IN_W   = 64;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 5;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } kls_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_HELD    = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } kls_status_e;

  // table contents and search results seen by the control logic
  typedef struct packed {
    logic [NUM_SLOTS-1:0] busy;
    logic [NUM_SLOTS-1:0] match;
    logic                 hit;
    logic [SLOT_W-1:0]    hit_idx;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;
  } kls_lookup_t;

  // one table write per request at most
  typedef struct packed {
    logic                set;
    logic                clr;
    logic [SLOT_W-1:0]   idx;
    logic [KEY_BITS-1:0] key;
  } kls_update_t;

  // low bits of a slot number as carried on the result channel
  function automatic logic [SLOT_OUT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+SLOT_OUT_W-1:0] ext;
    ext = (SLOT_W + SLOT_OUT_W)'(s);
    return ext[SLOT_OUT_W-1:0];
  endfunction

endpackage

>>> src/kls_if.sv
// request and result channel interfaces
interface kls_req_if;
  logic                          valid;
  logic                          ready;
  kls_pkg::kls_mode_e            mode;
  logic [kls_pkg::KEY_IN_W-1:0]  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface kls_rsp_if;
  logic                           valid;
  logic                           ready;
  kls_pkg::kls_status_e           status;
  logic [kls_pkg::SLOT_OUT_W-1:0] slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink (input valid, input status, input slot, output ready);
endinterface

>>> src/kls_prienc.sv
// lowest-set-bit priority encoder over the slot vector
module kls_prienc (
  input  logic [kls_pkg::NUM_SLOTS-1:0] vec_i,
  output logic                          found_o,
  output logic [kls_pkg::SLOT_W-1:0]    idx_o
);

  always_comb begin
    idx_o = '0;
    // scan downward so the lowest set bit wins
    for (int i = kls_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = kls_pkg::SLOT_W'(i);
      end
    end
  end

  assign found_o = |vec_i;

endmodule

>>> src/kls_slot_table.sv
// slot busy flags, owner keys, parallel key compare and slot search
module kls_slot_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [kls_pkg::KEY_BITS-1:0]   key_i,
  input  kls_pkg::kls_update_t           upd_i,
  output kls_pkg::kls_lookup_t           lk_o
);

  logic [kls_pkg::NUM_SLOTS-1:0] busy_q;
  logic [kls_pkg::KEY_BITS-1:0]  owner_q [kls_pkg::NUM_SLOTS];
  logic [kls_pkg::NUM_SLOTS-1:0] match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (upd_i.set) begin
      busy_q[upd_i.idx] <= 1'b1;
    end else if (upd_i.clr) begin
      busy_q[upd_i.idx] <= 1'b0;
    end
  end

  // owner keys are only looked at for busy slots
  always_ff @(posedge clk_i) begin
    if (upd_i.set) begin
      owner_q[upd_i.idx] <= upd_i.key;
    end
  end

  for (genvar g = 0; g < kls_pkg::NUM_SLOTS; g++) begin : g_cmp
    assign match[g] = busy_q[g] && (owner_q[g] == key_i);
  end

  kls_prienc u_hit_enc (
    .vec_i   (match),
    .found_o (lk_o.hit),
    .idx_o   (lk_o.hit_idx)
  );

  kls_prienc u_free_enc (
    .vec_i   (~busy_q),
    .found_o (lk_o.free_found),
    .idx_o   (lk_o.free_idx)
  );

  assign lk_o.busy  = busy_q;
  assign lk_o.match = match;

endmodule

>>> src/keyed_lowest_free_slot_allocator_top.sv
// keyed lowest-free-slot allocator: request register, table lookup, result register
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    mode, key
//   rsp_o    out  valid/ready    status, slot
//
// one request per cycle sustained while results are taken; a taken request passes
// through the request register, then through the key compare and the two priority
// encoders into the result register
// the table is written at the same edge that loads the result, so the next
// request sees the update with no gap
// reset frees every slot at once; no clearing pass
// a stalled result holds the result register, and one more request is held in
// the request register before req_i.ready drops
module keyed_lowest_free_slot_allocator_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  kls_req_if.sink   req_i,
  kls_rsp_if.source rsp_o
);

  logic                          in_valid_q;
  kls_pkg::kls_mode_e            mode_q;
  logic [kls_pkg::KEY_BITS-1:0]  key_q;

  logic                          out_valid_q;
  kls_pkg::kls_status_e          status_q;
  kls_pkg::kls_status_e          status_d;
  logic [kls_pkg::SLOT_OUT_W-1:0] slot_q;
  logic [kls_pkg::SLOT_W-1:0]    slot_d;

  logic                          fire;
  logic                          req_take;
  kls_pkg::kls_lookup_t          lk;
  kls_pkg::kls_update_t          upd;

  assign fire      = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || fire;
  assign req_take  = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      mode_q <= req_i.mode;
      key_q  <= req_i.key[kls_pkg::KEY_BITS-1:0];
    end
    if (fire) begin
      status_q <= status_d;
      slot_q   <= kls_pkg::slot_to_out(slot_d);
    end
  end

  kls_slot_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_q),
    .upd_i  (upd),
    .lk_o   (lk)
  );

  always_comb begin
    status_d = kls_pkg::ST_OK;
    slot_d   = '0;
    upd.set  = 1'b0;
    upd.clr  = 1'b0;
    upd.idx  = '0;
    upd.key  = key_q;
    case (mode_q)
      kls_pkg::MODE_ALLOC: begin
        if (lk.hit) begin
          status_d = kls_pkg::ST_HELD;
          slot_d   = lk.hit_idx;
        end else if (!lk.free_found) begin
          status_d = kls_pkg::ST_FULL;
        end else begin
          slot_d  = lk.free_idx;
          upd.set = fire;
          upd.idx = lk.free_idx;
        end
      end
      kls_pkg::MODE_RELEASE: begin
        if (!lk.hit) begin
          status_d = kls_pkg::ST_MISSING;
        end else begin
          slot_d  = lk.hit_idx;
          upd.clr = fire;
          upd.idx = lk.hit_idx;
        end
      end
      default: begin
        status_d = kls_pkg::ST_OK;
      end
    endcase
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = status_q;
  assign rsp_o.slot   = slot_q;

  // a key is never stored in two busy slots
  a_single_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(lk.match))
    else $error("key matches more than one busy slot");

  a_hit_not_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk.hit && lk.free_found |-> lk.hit_idx != lk.free_idx)
    else $error("matching slot also reported free");

  a_alloc_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd.set |=> $countones(lk.busy) == $past($countones(lk.busy)) + 1)
    else $error("allocation did not take exactly one slot");

  a_release_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd.clr |=> $countones(lk.busy) + 1 == $past($countones(lk.busy)))
    else $error("release did not free exactly one slot");

  a_stall_holds_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> in_valid_q && out_valid_q && !rsp_o.ready)
    else $error("request side stalled with no pending result");

endmodule
